// File: rtl/fdrle_pkg.sv
// ----------------------------------------------------------------------------
// fdrle_pkg
// Types and constants shared by the frame delta run-length encoder.
// ----------------------------------------------------------------------------
package fdrle_pkg;

  localparam int unsigned FRAME_PIXELS_DEF = 1048576;
  localparam int unsigned MAX_RUN_DEF      = 255;

  localparam int unsigned ColorW = 24;
  localparam int unsigned IndexW = 20;
  localparam int unsigned CountW = 8;
  localparam int unsigned StoreW = ColorW + 1;  // written mark on top

  // range check is done at this width so that frame sizes below 2^25 fit
  localparam int unsigned LimitW = 25;

  localparam logic [ColorW-1:0] UNCHANGED_CODE = 24'h000001;

  // front to back queue, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic [IndexW-1:0] pixel_index;
    logic              first_pixel;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [CountW-1:0] run_count;
    logic [ColorW-1:0] run_code;
    logic              last_run;
  } run_t;

  typedef struct packed {
    logic [ColorW-1:0] code;
    logic              first;
    logic              last;
  } code_item_t;

  typedef struct packed {
    logic clearing;
    logic stage_valid;
  } front_status_t;

endpackage

// File: rtl/fdrle_front.sv
// ----------------------------------------------------------------------------
// fdrle_front
// Frame store lookup and pixel classification: pixel or unchanged code.
// ----------------------------------------------------------------------------
module fdrle_front import fdrle_pkg::*; #(
  parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pixel_t        in_data_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output code_item_t    q_data_o,
  output front_status_t status_o
);

  localparam int unsigned StoreDepth =
      (FRAME_PIXELS < (1 << IndexW)) ? FRAME_PIXELS : (1 << IndexW);
  localparam int unsigned AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [LimitW-1:0] FrameLimit = LimitW'(FRAME_PIXELS);
  localparam logic [AddrW:0]    LastAddr   = (AddrW+1)'(StoreDepth - 1);

  logic [StoreW-1:0] mem_q [StoreDepth];
  logic [StoreW-1:0] rdata_q;

  logic              clearing_q, clearing_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic              b_valid_q, b_valid_d;
  pixel_t            b_item_q;
  logic              b_in_range_q;
  logic              fwd_q;
  logic [ColorW-1:0] fwd_color_q;

  logic              accept, b_advance, in_range, fwd_d, same;
  logic [AddrW-1:0]  raddr, waddr;
  logic [StoreW-1:0] wdata, prev;
  logic              we;

  assign b_advance  = b_valid_q && q_ready_i;
  assign in_ready_o = !clearing_q && (!b_valid_q || q_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {{(LimitW-IndexW){1'b0}}, in_data_i.pixel_index} < FrameLimit;
  assign raddr      = in_range ? in_data_i.pixel_index[AddrW-1:0] : '0;

  // the store write of the word in the stage lands after the read of the
  // word behind it, so that case is bypassed
  assign fwd_d = b_advance && b_in_range_q &&
                 (b_item_q.pixel_index == in_data_i.pixel_index);

  assign prev = fwd_q ? {1'b1, fwd_color_q} : rdata_q;
  assign same = b_in_range_q && prev[StoreW-1] &&
                (prev[ColorW-1:0] == b_item_q.pixel_color);

  assign we    = clearing_q || (b_advance && b_in_range_q);
  assign waddr = clearing_q ? clr_addr_q : b_item_q.pixel_index[AddrW-1:0];
  assign wdata = clearing_q ? '0 : {1'b1, b_item_q.pixel_color};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (accept) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      if ({1'b0, clr_addr_q} == LastAddr) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (accept) begin
      b_valid_d = 1'b1;
    end else if (b_advance) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      b_valid_q  <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_item_q     <= in_data_i;
      b_in_range_q <= in_range;
      fwd_q        <= fwd_d;
      fwd_color_q  <= b_item_q.pixel_color;
    end
  end

  assign q_valid_o      = b_valid_q;
  assign q_data_o.code  = same ? UNCHANGED_CODE : b_item_q.pixel_color;
  assign q_data_o.first = b_item_q.first_pixel;
  assign q_data_o.last  = b_item_q.last_pixel;

  assign status_o.clearing    = clearing_q;
  assign status_o.stage_valid = b_valid_q;

endmodule

// File: rtl/fdrle_queue.sv
// ----------------------------------------------------------------------------
// fdrle_queue
// Short FIFO of classified codes between the front and the run engine.
// ----------------------------------------------------------------------------
module fdrle_queue import fdrle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  code_item_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output code_item_t pop_data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW:0] Full = (PtrW+1)'(QUEUE_DEPTH);

  code_item_t       fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

endmodule

// File: rtl/fdrle_back.sv
// ----------------------------------------------------------------------------
// fdrle_back
// Run engine: extends, breaks and flushes runs into a two-word output buffer.
// ----------------------------------------------------------------------------
module fdrle_back import fdrle_pkg::*; #(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  code_item_t q_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output run_t       out_data_o
);

  localparam logic [CountW-1:0] MaxRun = CountW'(MAX_RUN);

  logic [ColorW-1:0] open_code_q, open_code_d;
  logic [CountW-1:0] open_count_q, open_count_d;
  run_t              obuf_q [2];
  run_t              obuf_d [2];
  logic [1:0]        ocnt_q, ocnt_d, ocnt_mid;

  logic              out_pop, same_run, brk, restart, take;
  logic [1:0]        avail, n_words;
  logic [CountW-1:0] new_count;
  logic [ColorW-1:0] new_code;
  run_t              r0, r1;

  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_data_o  = obuf_q[0];
  assign out_pop     = out_valid_o && out_ready_i;
  assign avail       = 2'd2 - ocnt_q + {1'b0, out_pop};

  assign same_run  = (q_data_i.code == open_code_q) && (open_count_q < MaxRun);
  assign brk       = !q_data_i.first && (open_count_q != '0) && !same_run;
  assign restart   = q_data_i.first || (open_count_q == '0) || brk;
  assign new_count = restart ? CountW'(1) : open_count_q + 1'b1;
  assign new_code  = restart ? q_data_i.code : open_code_q;
  assign n_words   = {1'b0, brk} + {1'b0, q_data_i.last};

  // broken run goes out first, the flush after it
  assign r1 = run_t'{run_count: new_count, run_code: new_code, last_run: 1'b1};
  assign r0 = brk ? run_t'{run_count: open_count_q, run_code: open_code_q, last_run: 1'b0}
                  : r1;

  assign take      = q_valid_i && (n_words <= avail);
  assign q_ready_o = (n_words <= avail);

  always_comb begin
    open_code_d  = open_code_q;
    open_count_d = open_count_q;
    if (take) begin
      if (q_data_i.last) begin
        open_code_d  = '0;
        open_count_d = '0;
      end else begin
        open_code_d  = new_code;
        open_count_d = new_count;
      end
    end
  end

  always_comb begin
    obuf_d   = obuf_q;
    ocnt_mid = ocnt_q;
    if (out_pop) begin
      obuf_d[0] = obuf_q[1];
      ocnt_mid  = ocnt_q - 2'd1;
    end
    ocnt_d = ocnt_mid;
    if (take) begin
      case (n_words)
        2'd1: begin
          obuf_d[ocnt_mid[0]] = r0;
        end
        2'd2: begin
          obuf_d[0] = r0;
          obuf_d[1] = r1;
        end
        default: ;
      endcase
      ocnt_d = ocnt_mid + n_words;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_code_q  <= '0;
      open_count_q <= '0;
      ocnt_q       <= 2'd0;
    end else begin
      open_code_q  <= open_code_d;
      open_count_q <= open_count_d;
      ocnt_q       <= ocnt_d;
    end
  end

endmodule

// File: rtl/frame_delta_run_length_encoder.sv
// ----------------------------------------------------------------------------
// frame_delta_run_length_encoder
// Compares pixels with the previous frame and run-length encodes the codes.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one pixel word per
// clock: color, frame store index and first/last marks of a rectangle.
// Output channel (out_valid_o/out_ready_i/out_data_o) gives run words:
// count, code (color, or 1 for unchanged) and last_run on the flush word.
// Throughput: one pixel per clock while nothing stalls; a pixel that both
// breaks a run and closes the rectangle gives two words. The output buffer
// drains one word per clock while out_ready_i is high, so back-to-back
// pixels of that kind cannot be taken one per clock.
// Path: store read into classify stage, then queue, then run engine into
// output buffer, which drives the output channel.
// Reset: the frame store is swept to "unwritten" one entry per clock,
// min(FRAME_PIXELS, 2^20) entries, with in_ready_o low meanwhile. The open
// run is cleared at once.
// Receiver stall: the two-word output buffer fills, then the code queue,
// then in_ready_o drops; nothing is lost.
// ----------------------------------------------------------------------------
module frame_delta_run_length_encoder import fdrle_pkg::*; #(
  parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEF,
  parameter int unsigned MAX_RUN      = MAX_RUN_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output run_t   out_data_o
);

  logic          f_valid, f_ready, b_valid, b_ready;
  code_item_t    f_data, b_data;
  front_status_t front_status;

  fdrle_front #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_data_o   (f_data),
    .status_o   (front_status)
  );

  fdrle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  fdrle_back #(
    .MAX_RUN(MAX_RUN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_data_i    (b_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  localparam logic [CountW-1:0] MaxRunChk = CountW'(MAX_RUN);

  a_run_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_count != '0) &&
                    (out_data_o.run_count <= MaxRunChk))
    else $error("run word count out of range");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.clearing |-> !in_ready_o)
    else $error("pixel accepted during store clear");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> front_status.stage_valid)
    else $error("accepted pixel missing from classify stage");

endmodule
